// ===== rtl/ks2_pkg.sv =====
// shared constants and types for the two-sample ks statistic block
package ks2_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int VALUE_W = 32;
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int PROD_W = 2 * CNT_W;
   localparam int FRAC_W = 16;
   localparam int Q_W = FRAC_W + 1;
   localparam int NUM_W = 21;
   localparam int DEN_W = 21;
   localparam int RSP_FIELDS_W = NUM_W + DEN_W + Q_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DATA_W - RSP_FIELDS_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // flipping the sign bit gives an unsigned key with the same order
   localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W - 1) {1'b0}}};

   localparam logic SEL_A = 1'b0;
   localparam logic SEL_B = 1'b1;

   typedef struct packed {
      logic               is_b;
      logic               last;
      logic [VALUE_W-1:0] key;
   } cmd_type;

endpackage

// ===== rtl/ks2_front.sv =====
// front end: accepts sample words and turns them into load commands
module ks2_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ks2_pkg::VALUE_W-1:0]  req_tdata,   // value
   input  logic                         req_tuser,   // func
   input  logic                         req_tlast,   // last
   output ks2_pkg::cmd_type             push_cmd,
   output logic                         push_valid,
   input  logic                         push_ready
);

   logic             hold_valid_ff, hold_valid_in;
   ks2_pkg::cmd_type hold_ff, hold_in;
   logic             req_acc;

   assign req_tready = !hold_valid_ff || push_ready;
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in = hold_ff;
      if (req_acc) begin
         hold_valid_in = 1'b1;
         hold_in.is_b = (req_tuser == ks2_pkg::SEL_B);
         hold_in.last = req_tlast;
         hold_in.key = req_tdata ^ ks2_pkg::SIGN_FLIP;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign push_cmd = hold_ff;
   assign push_valid = hold_valid_ff;

endmodule

// ===== rtl/ks2_queue.sv =====
// short command queue between the front end and the merge engine
module ks2_queue (
   input  logic             clock,
   input  logic             reset,
   input  ks2_pkg::cmd_type push_cmd,
   input  logic             push_valid,
   output logic             push_ready,
   output ks2_pkg::cmd_type pop_cmd,
   output logic             pop_valid,
   input  logic             pop_ready
);

   ks2_pkg::cmd_type               slots [ks2_pkg::QUEUE_DEPTH];
   logic [ks2_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ks2_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ks2_pkg::QPTR_W:0]       count_ff, count_in;
   logic                           do_push, do_pop;

   assign push_ready = (count_ff != (ks2_pkg::QPTR_W + 1)'(ks2_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = slots[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/ks2_div.sv =====
// restoring divider, one quotient bit a cycle, gives round(num/den) in q1.16
module ks2_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ks2_pkg::PROD_W-1:0]  num,
   input  logic [ks2_pkg::PROD_W-1:0]  den,
   output logic                        done,
   output logic [ks2_pkg::Q_W-1:0]     quot
);

   localparam int N_W = ks2_pkg::PROD_W + ks2_pkg::Q_W;
   localparam int CNT_W = $clog2(ks2_pkg::Q_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [ks2_pkg::PROD_W-1:0]    rem_ff, rem_in;
   logic [ks2_pkg::PROD_W-1:0]    den_ff, den_in;
   logic [ks2_pkg::Q_W-1:0]       low_ff, low_in;
   logic [ks2_pkg::Q_W-1:0]       quot_ff, quot_in;
   logic [N_W-1:0]                dividend;
   logic [ks2_pkg::PROD_W:0]      trial;
   logic                          fits;

   // numerator shifted up by the fraction bits plus half the divisor for rounding
   assign dividend = ({num, {ks2_pkg::Q_W {1'b0}}} >> 1)
                     + N_W'(den >> 1);
   assign trial = {rem_ff, low_ff[ks2_pkg::Q_W-1]};
   assign fits = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      low_in = low_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(ks2_pkg::Q_W);
         den_in = den;
         // quotient stays below 2^Q_W, so the top part is already below den
         rem_in = dividend[N_W-1:ks2_pkg::Q_W];
         low_in = dividend[ks2_pkg::Q_W-1:0];
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in = fits ? ks2_pkg::PROD_W'(trial - {1'b0, den_ff})
                       : trial[ks2_pkg::PROD_W-1:0];
         low_in = {low_ff[ks2_pkg::Q_W-2:0], 1'b0};
         quot_in = {quot_ff[ks2_pkg::Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/ks2_back.sv =====
// merge engine: stores both samples, walks them and forms the result word
module ks2_back (
   input  logic                             clock,
   input  logic                             reset,
   input  ks2_pkg::cmd_type                 pop_cmd,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ks2_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_START,
      S_PICK,
      S_ADV,
      S_DIFF,
      S_DIV,
      S_OUT
   } state_type;

   state_type                        state_ff, state_in;
   logic [ks2_pkg::CNT_W-1:0]        size_a_ff, size_a_in, size_b_ff, size_b_in;
   logic [ks2_pkg::CNT_W-1:0]        ia_ff, ia_in, ib_ff, ib_in;
   logic [ks2_pkg::VALUE_W-1:0]      t_ff, t_in;
   logic [ks2_pkg::PROD_W-1:0]       pa_ff, pa_in, pb_ff, pb_in;
   logic [ks2_pkg::PROD_W-1:0]       max_ff, max_in, den_ff, den_in;
   logic [ks2_pkg::Q_W-1:0]          q_ff, q_in;
   logic                             err_ff, err_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ks2_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                             rsp_err_ff, rsp_err_in;

   logic [ks2_pkg::VALUE_W-1:0]      mem_a [ks2_pkg::MAX_SAMPLES];
   logic [ks2_pkg::VALUE_W-1:0]      mem_b [ks2_pkg::MAX_SAMPLES];
   logic [ks2_pkg::VALUE_W-1:0]      head_a_ff, head_b_ff;

   logic                             pop, wr_a, wr_b;
   logic                             avail_a, avail_b, adv_a, adv_b;
   logic [ks2_pkg::VALUE_W-1:0]      pick;
   logic [ks2_pkg::PROD_W-1:0]       diff;
   logic                             div_start, div_done;
   logic [ks2_pkg::Q_W-1:0]          div_q;
   logic                             out_free;

   assign pop = pop_valid && (state_ff == S_LOAD);
   assign pop_ready = (state_ff == S_LOAD);
   assign wr_a = pop && (pop_cmd.is_b == ks2_pkg::SEL_A)
                 && (size_a_ff < ks2_pkg::CNT_W'(ks2_pkg::MAX_SAMPLES));
   assign wr_b = pop && (pop_cmd.is_b == ks2_pkg::SEL_B)
                 && (size_b_ff < ks2_pkg::CNT_W'(ks2_pkg::MAX_SAMPLES));

   assign avail_a = (ia_ff < size_a_ff);
   assign avail_b = (ib_ff < size_b_ff);
   assign adv_a = avail_a && (head_a_ff <= t_ff);
   assign adv_b = avail_b && (head_b_ff <= t_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next walk value: smaller head of the samples that still have elements
   always_comb begin
      if (!avail_a) begin
         pick = head_b_ff;
      end else if (!avail_b) begin
         pick = head_a_ff;
      end else begin
         pick = (head_a_ff < head_b_ff) ? head_a_ff : head_b_ff;
      end
   end

   assign diff = (pa_ff > pb_ff) ? pa_ff - pb_ff : pb_ff - pa_ff;

   always_comb begin
      state_in = state_ff;
      size_a_in = wr_a ? size_a_ff + 1'b1 : size_a_ff;
      size_b_in = wr_b ? size_b_ff + 1'b1 : size_b_ff;
      ia_in = ia_ff;
      ib_in = ib_ff;
      t_in = t_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      max_in = max_ff;
      den_in = den_ff;
      q_in = q_ff;
      err_in = err_ff;
      div_start = 1'b0;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_err_in = rsp_err_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (pop && pop_cmd.last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            den_in = ks2_pkg::PROD_W'(size_a_ff) * ks2_pkg::PROD_W'(size_b_ff);
            q_in = '0;
            if (size_a_ff == '0 || size_b_ff == '0) begin
               err_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            t_in = pick;
            state_in = S_ADV;
         end
         S_ADV: begin
            if (adv_a || adv_b) begin
               ia_in = adv_a ? ia_ff + 1'b1 : ia_ff;
               ib_in = adv_b ? ib_ff + 1'b1 : ib_ff;
            end else begin
               pa_in = ks2_pkg::PROD_W'(ia_ff) * ks2_pkg::PROD_W'(size_b_ff);
               pb_in = ks2_pkg::PROD_W'(ib_ff) * ks2_pkg::PROD_W'(size_a_ff);
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            if (diff > max_ff) begin
               max_in = diff;
            end
            if (avail_a || avail_b) begin
               t_in = pick;
               state_in = S_ADV;
            end else begin
               div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               q_in = div_q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in = err_ff;
               rsp_data_in = {{ks2_pkg::RSP_PAD_W {1'b0}}, q_ff,
                              den_ff[ks2_pkg::DEN_W-1:0], max_ff[ks2_pkg::NUM_W-1:0]};
               size_a_in = '0;
               size_b_in = '0;
               ia_in = '0;
               ib_in = '0;
               max_in = '0;
               err_in = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         size_a_ff <= '0;
         size_b_ff <= '0;
         ia_ff <= '0;
         ib_ff <= '0;
         max_ff <= '0;
         err_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_a_ff <= size_a_in;
         size_b_ff <= size_b_in;
         ia_ff <= ia_in;
         ib_ff <= ib_in;
         max_ff <= max_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff <= t_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      den_ff <= den_in;
      q_ff <= q_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff <= rsp_err_in;
   end

   // heads are read at the next walk index so they line up with ia_ff and ib_ff
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[size_a_ff[ks2_pkg::ADDR_W-1:0]] <= pop_cmd.key;
      end
      if (wr_b) begin
         mem_b[size_b_ff[ks2_pkg::ADDR_W-1:0]] <= pop_cmd.key;
      end
      head_a_ff <= mem_a[ia_in[ks2_pkg::ADDR_W-1:0]];
      head_b_ff <= mem_b[ib_in[ks2_pkg::ADDR_W-1:0]];
   end

   ks2_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (max_in),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_err_ff;

`ifndef ASSERT_OFF
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (ia_ff <= size_a_ff) && (ib_ff <= size_b_ff))
      else $error("walk index past sample size");

   a_max_le_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (max_ff <= den_ff))
      else $error("numerator above denominator");

   a_walk_moves: assert property (@(posedge clock) disable iff (reset)
      (state_in == S_ADV && state_ff != S_ADV) |=> (adv_a || adv_b))
      else $error("new walk value advances no sample");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && state_in == S_LOAD)
      |=> (size_a_ff == '0 && size_b_ff == '0 && max_ff == '0 && !err_ff))
      else $error("data set not cleared after result");
`endif

endmodule

// ===== rtl/two_sample_ks_statistic.sv =====
// Two-sample KS statistic engine. Each input word loads one value (tdata) into sample A
// (tuser 0) or sample B (tuser 1); both samples must arrive in ascending order. Loading
// is buffered by a four-entry command queue. The word with tlast set is loaded and then
// starts the merge walk, run from the two sample memories one element read per sample per
// cycle: a start step and a pick step, then per distinct value the advance steps plus the
// product and maximum update, followed by a bit-serial divide and a step to post the
// result. Words for the next data set queue up meanwhile and are loaded once the result
// is posted. One result word follows each tlast word: numerator, nA*nB and the rounded
// Q1.16 quotient in tdata, and tuser set when a sample was empty (all fields zero). Each
// sample holds at most 1024 values; extra values are dropped.
module two_sample_ks_statistic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ks2_pkg::VALUE_W-1:0]      req_tdata,   // value
   input  logic                             req_tuser,   // func
   input  logic                             req_tlast,   // last
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ks2_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // stat_num, stat_den, stat_q16
   output logic                             rsp_tuser    // empty_error
);

   ks2_pkg::cmd_type push_cmd, pop_cmd;
   logic             push_valid, push_ready, pop_valid, pop_ready;

   ks2_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ks2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   ks2_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
